[rtl/core/relative_pose_from_consecutive_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the relative pose block
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef RELATIVE_POSE_FROM_CONSECUTIVE_TOP_ASSERT_SVH
`define RELATIVE_POSE_FROM_CONSECUTIVE_TOP_ASSERT_SVH

// same-cycle implication
`define RPFC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RPFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/rpfc_pkg.sv]
// ----------------------------------------------------------------------------
// rpfc_pkg
// Widths, job codes and the cofactor index table of the relative pose block.
// ----------------------------------------------------------------------------
package rpfc_pkg;

   localparam int DATA_W  = 32;
   localparam int ACC_W   = 100;          // exact sums of products
   localparam int DIV_W   = ACC_W + 32;   // scaled dividend
   localparam int Q_BITS  = 32;           // quotient bits produced serially
   localparam int N_POSE  = 12;
   localparam int N_COF   = 9;

   // job codes: 0..8 cofactors, then determinant, then 12 numerators
   localparam logic [4:0] JOB_DET  = 5'd9;
   localparam logic [4:0] JOB_NUM0 = 5'd10;
   localparam logic [4:0] JOB_LAST = 5'd21;

   localparam logic [2:0] TERM_COF_LAST = 3'd1;
   localparam logic [2:0] TERM_SUM_LAST = 3'd5;

   typedef struct packed {
      logic [1:0] row_a;
      logic [1:0] row_b;
      logic [1:0] col_1;
      logic [1:0] col_2;
   } cof_rows_type;

   // cofactor k*3+c = row(k+1) x row(k+2), component c
   function automatic cof_rows_type cof_rows(input logic [3:0] job);
      cof_rows_type r;
      case (job)
         4'd0:    r = '{2'd1, 2'd2, 2'd1, 2'd2};
         4'd1:    r = '{2'd1, 2'd2, 2'd2, 2'd0};
         4'd2:    r = '{2'd1, 2'd2, 2'd0, 2'd1};
         4'd3:    r = '{2'd2, 2'd0, 2'd1, 2'd2};
         4'd4:    r = '{2'd2, 2'd0, 2'd2, 2'd0};
         4'd5:    r = '{2'd2, 2'd0, 2'd0, 2'd1};
         4'd6:    r = '{2'd0, 2'd1, 2'd1, 2'd2};
         4'd7:    r = '{2'd0, 2'd1, 2'd2, 2'd0};
         4'd8:    r = '{2'd0, 2'd1, 2'd0, 2'd1};
         default: r = '{2'd0, 2'd0, 2'd0, 2'd0};
      endcase
      return r;
   endfunction

endpackage

[rtl/core/rpfc_div.sv]
// ----------------------------------------------------------------------------
// rpfc_div
// Bit-serial rounding divider: round(num * 2^30 / den), saturated to 32 bits.
// ----------------------------------------------------------------------------
module rpfc_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [rpfc_pkg::ACC_W-1:0]      num,
   input  logic signed [rpfc_pkg::ACC_W-1:0]      den,
   output logic                                   done,
   output logic signed [rpfc_pkg::DATA_W-1:0]     quo
);

   typedef enum logic [4:0] {
      D_IDLE = 5'b00001,
      D_PREP = 5'b00010,
      D_CHK  = 5'b00100,
      D_RUN  = 5'b01000,
      D_DONE = 5'b10000
   } div_state_type;

   localparam int          AW      = rpfc_pkg::ACC_W;
   localparam int          DW      = rpfc_pkg::DIV_W;
   localparam logic [4:0]  CNT_END = 5'(rpfc_pkg::Q_BITS - 1);

   div_state_type             state_ff;
   logic signed [AW-1:0]      num_ff, den_ff;
   logic        [AW-1:0]      md_ff;
   logic        [DW-1:0]      nsh_ff;
   logic        [AW:0]        rem_ff;
   logic        [31:0]        lo_ff, q_ff;
   logic        [4:0]         cnt_ff;
   logic                      neg_ff, nn_ff, nz_ff, dz_ff, ovf_ff;

   logic        [AW-1:0]      mn, md;
   logic        [DW-1:0]      nsh_in;
   logic        [AW:0]        trial;
   logic                      ge;
   logic        [31:0]        lim;

   always_comb begin
      mn     = num_ff[AW-1] ? AW'(-num_ff) : AW'(num_ff);
      md     = den_ff[AW-1] ? AW'(-den_ff) : AW'(den_ff);
      nsh_in = DW'({mn, 30'b0}) + DW'(md >> 1);
      trial  = {rem_ff[AW-1:0], lo_ff[31]};
      ge     = trial >= {1'b0, md_ff};
      lim    = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  num_ff   <= num;
                  den_ff   <= den;
                  state_ff <= D_PREP;
               end
            end
            D_PREP: begin
               md_ff  <= md;
               nsh_ff <= nsh_in;
               nn_ff  <= num_ff[AW-1];
               nz_ff  <= (num_ff == '0);
               dz_ff  <= (md == '0);
               neg_ff <= num_ff[AW-1] ^ den_ff[AW-1];
               ovf_ff <= 1'b0;
               q_ff   <= '0;
               state_ff <= (md == '0) ? D_DONE : D_CHK;
            end
            D_CHK: begin
               rem_ff <= {1'b0, nsh_ff[DW-1:32]};
               lo_ff  <= nsh_ff[31:0];
               cnt_ff <= '0;
               if (nsh_ff >= {md_ff, 32'b0}) begin
                  ovf_ff   <= 1'b1;
                  state_ff <= D_DONE;
               end else begin
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff <= ge ? (trial - {1'b0, md_ff}) : trial;
               q_ff   <= {q_ff[30:0], ge};
               lo_ff  <= {lo_ff[30:0], 1'b0};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == CNT_END) begin
                  state_ff <= D_DONE;
               end
            end
            D_DONE: begin
               state_ff <= D_IDLE;
            end
            default: begin
               state_ff <= D_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      done = (state_ff == D_DONE);
      if (dz_ff) begin
         // singular: sign of the numerator only
         quo = nz_ff ? 32'sd0 : (nn_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
      end else if (ovf_ff || (q_ff > lim)) begin
         quo = signed'(lim);
         if (neg_ff) begin
            quo = 32'sh8000_0000;
         end
      end else begin
         quo = neg_ff ? signed'(-q_ff) : signed'(q_ff);
      end
   end

endmodule

[rtl/core/relative_pose_from_consecutive_top.sv]
// ----------------------------------------------------------------------------
// relative_pose_from_consecutive_top
// Relative pose of consecutive 3x4 affine poses: inv(P_prev) * P_cur.
// ----------------------------------------------------------------------------
// Usage: req_* carries one absolute pose per item (nine Q2.30 linear entries,
//   three Q16.16 translations, row by row); rsp_* carries the relative pose in
//   the same layout, rounded to nearest and saturated. The first item after
//   reset only primes the stored pose; every later item gives one result.
// Schedule: one 33x33 multiplier; each product term passes through the
//   load, multiply and accumulate states. Nine cofactors (2 terms +
//   store), the determinant (6 terms + store), twelve numerators (6 terms,
//   store, bit-serial divide). A divide ends early on a singular or
//   overflowing quotient. req_stall stays high for the whole computation, so
//   no item is taken before the last is done; a priming item causes no stall.
// Reset: synchronous, active high. Clears the sequencer, the stored-pose flag
//   and rsp_valid; the next item is treated as the first.
// Stall: a result sits in the output register while rsp_stall is high. The
//   block accepts and works on the next item meanwhile, and holds its
//   finished result internally until the output register is free.
// ----------------------------------------------------------------------------
module relative_pose_from_consecutive_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_cur_r00,
   input  logic signed [31:0] req_cur_r01,
   input  logic signed [31:0] req_cur_r02,
   input  logic signed [31:0] req_cur_tx,
   input  logic signed [31:0] req_cur_r10,
   input  logic signed [31:0] req_cur_r11,
   input  logic signed [31:0] req_cur_r12,
   input  logic signed [31:0] req_cur_ty,
   input  logic signed [31:0] req_cur_r20,
   input  logic signed [31:0] req_cur_r21,
   input  logic signed [31:0] req_cur_r22,
   input  logic signed [31:0] req_cur_tz,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_rel_r00,
   output logic signed [31:0] rsp_rel_r01,
   output logic signed [31:0] rsp_rel_r02,
   output logic signed [31:0] rsp_rel_tx,
   output logic signed [31:0] rsp_rel_r10,
   output logic signed [31:0] rsp_rel_r11,
   output logic signed [31:0] rsp_rel_r12,
   output logic signed [31:0] rsp_rel_ty,
   output logic signed [31:0] rsp_rel_r20,
   output logic signed [31:0] rsp_rel_r21,
   output logic signed [31:0] rsp_rel_r22,
   output logic signed [31:0] rsp_rel_tz
);

   localparam int AW = rpfc_pkg::ACC_W;

   // sequencer: load operand A, multiply by B, accumulate, then store/divide
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LD    = 7'b0000010,
      ST_MUL   = 7'b0000100,
      ST_ACC   = 7'b0001000,
      ST_STORE = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type            state_ff;
   logic                 have_prev_ff;
   logic                 rsp_valid_ff;
   logic [4:0]           job_ff;
   logic [2:0]           term_ff;

   logic signed [31:0]   req_pose [rpfc_pkg::N_POSE];
   logic signed [31:0]   cur_ff   [rpfc_pkg::N_POSE];
   logic signed [31:0]   prev_ff  [rpfc_pkg::N_POSE];
   logic signed [31:0]   res_ff   [rpfc_pkg::N_POSE];
   logic signed [31:0]   rsp_ff   [rpfc_pkg::N_POSE];
   logic        [63:0]   cof_ff   [rpfc_pkg::N_COF];

   logic signed [AW-1:0] acc_ff, det_ff;
   logic signed [32:0]   opa_ff;
   logic signed [65:0]   prod_ff;

   // term decode
   rpfc_pkg::cof_rows_type cr;
   logic [1:0]           tk;
   logic                 th;
   logic [4:0]           noff;
   logic [3:0]           nidx;
   logic [3:0]           a_idx, b_idx, cof_idx, prev_idx;
   logic                 a_cof, b_cur, b_dv, sub, sh;
   logic [2:0]           last_term;
   logic signed [31:0]   prev_rd, cur_rd;
   logic        [63:0]   cof_rd;
   logic signed [32:0]   a_val, b_val;
   logic signed [AW-1:0] prod_ext, addend, acc_in;

   logic                 req_take, out_free;
   logic                 div_start, div_done;
   logic signed [31:0]   div_quo;

   assign req_pose[0]  = req_cur_r00;
   assign req_pose[1]  = req_cur_r01;
   assign req_pose[2]  = req_cur_r02;
   assign req_pose[3]  = req_cur_tx;
   assign req_pose[4]  = req_cur_r10;
   assign req_pose[5]  = req_cur_r11;
   assign req_pose[6]  = req_cur_r12;
   assign req_pose[7]  = req_cur_ty;
   assign req_pose[8]  = req_cur_r20;
   assign req_pose[9]  = req_cur_r21;
   assign req_pose[10] = req_cur_r22;
   assign req_pose[11] = req_cur_tz;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cr        = rpfc_pkg::cof_rows(job_ff[3:0]);
      tk        = term_ff[2:1];
      th        = term_ff[0];
      noff      = job_ff - rpfc_pkg::JOB_NUM0;
      nidx      = noff[3:0];
      a_idx     = '0;
      b_idx     = '0;
      cof_idx   = '0;
      a_cof     = 1'b0;
      b_cur     = 1'b0;
      b_dv      = 1'b0;
      sub       = 1'b0;
      sh        = 1'b0;
      last_term = rpfc_pkg::TERM_SUM_LAST;
      if (job_ff < rpfc_pkg::JOB_DET) begin
         // cofactor: a1*b2 - a2*b1 on two rows of the previous pose
         last_term = rpfc_pkg::TERM_COF_LAST;
         if (th) begin
            a_idx = {cr.row_a, cr.col_2};
            b_idx = {cr.row_b, cr.col_1};
            sub   = 1'b1;
         end else begin
            a_idx = {cr.row_a, cr.col_1};
            b_idx = {cr.row_b, cr.col_2};
         end
      end else if (job_ff == rpfc_pkg::JOB_DET) begin
         // det = sum p[0][k] * cof[k], cofactor split in halves
         a_cof   = 1'b1;
         cof_idx = {2'b00, tk};
         b_idx   = {2'b00, tk};
         sh      = th;
      end else begin
         // numerator (i, j) = sum cof[k*3+i] * cur[k][j] (or dv[k] for j = 3)
         a_cof   = 1'b1;
         cof_idx = {1'b0, tk, 1'b0} + {2'b00, tk} + {2'b00, nidx[3:2]};
         b_idx   = {tk, nidx[1:0]};
         b_cur   = (nidx[1:0] != 2'd3);
         b_dv    = (nidx[1:0] == 2'd3);
         sh      = th;
      end

      prev_idx = (state_ff == ST_LD) ? a_idx : b_idx;
      prev_rd  = prev_ff[prev_idx];
      cur_rd   = cur_ff[b_idx];
      cof_rd   = cof_ff[cof_idx];

      if (a_cof) begin
         a_val = th ? 33'(signed'(cof_rd[63:32])) : signed'({1'b0, cof_rd[31:0]});
      end else begin
         a_val = 33'(prev_rd);
      end

      if (b_dv) begin
         b_val = 33'(cur_rd) - 33'(prev_rd);
      end else if (b_cur) begin
         b_val = 33'(cur_rd);
      end else begin
         b_val = 33'(prev_rd);
      end

      prod_ext = AW'(prod_ff);
      addend   = sh ? (prod_ext <<< 32) : prod_ext;
      acc_in   = sub ? (acc_ff - addend) : (acc_ff + addend);
   end

   assign div_start = (state_ff == ST_STORE) && (job_ff >= rpfc_pkg::JOB_NUM0);

   rpfc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (acc_ff),
      .den   (det_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         job_ff       <= '0;
         term_ff      <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  have_prev_ff <= 1'b1;
                  job_ff       <= '0;
                  term_ff      <= '0;
                  if (have_prev_ff) begin
                     state_ff <= ST_LD;
                  end
               end
            end
            ST_LD: begin
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (term_ff == last_term) begin
                  state_ff <= ST_STORE;
               end else begin
                  term_ff  <= term_ff + 3'd1;
                  state_ff <= ST_LD;
               end
            end
            ST_STORE: begin
               term_ff <= '0;
               if (job_ff >= rpfc_pkg::JOB_NUM0) begin
                  state_ff <= ST_DIV;
               end else begin
                  job_ff   <= job_ff + 5'd1;
                  state_ff <= ST_LD;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  if (job_ff == rpfc_pkg::JOB_LAST) begin
                     state_ff <= ST_OUT;
                  end else begin
                     job_ff   <= job_ff + 5'd1;
                     state_ff <= ST_LD;
                  end
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         // output register: load a finished item, drop one that was taken
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            acc_ff <= '0;
            if (req_take) begin
               for (int i = 0; i < rpfc_pkg::N_POSE; i++) begin
                  cur_ff[i] <= req_pose[i];
                  if (!have_prev_ff) begin
                     prev_ff[i] <= req_pose[i];
                  end
               end
            end
         end
         ST_LD: begin
            opa_ff <= a_val;
         end
         ST_MUL: begin
            prod_ff <= opa_ff * b_val;
         end
         ST_ACC: begin
            acc_ff <= acc_in;
         end
         ST_STORE: begin
            if (job_ff < rpfc_pkg::JOB_DET) begin
               cof_ff[job_ff[3:0]] <= acc_ff[63:0];
            end
            if (job_ff == rpfc_pkg::JOB_DET) begin
               det_ff <= acc_ff;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_ff[nidx] <= div_quo;
               acc_ff       <= '0;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               for (int i = 0; i < rpfc_pkg::N_POSE; i++) begin
                  rsp_ff[i]  <= res_ff[i];
                  prev_ff[i] <= cur_ff[i];
               end
            end
         end
         default: begin
            acc_ff <= '0;
         end
      endcase
      // cofactor/det jobs restart the sum after the store
      if (state_ff == ST_STORE && job_ff < rpfc_pkg::JOB_NUM0) begin
         acc_ff <= '0;
      end
   end

   assign rsp_rel_r00 = rsp_ff[0];
   assign rsp_rel_r01 = rsp_ff[1];
   assign rsp_rel_r02 = rsp_ff[2];
   assign rsp_rel_tx  = rsp_ff[3];
   assign rsp_rel_r10 = rsp_ff[4];
   assign rsp_rel_r11 = rsp_ff[5];
   assign rsp_rel_r12 = rsp_ff[6];
   assign rsp_rel_ty  = rsp_ff[7];
   assign rsp_rel_r20 = rsp_ff[8];
   assign rsp_rel_r21 = rsp_ff[9];
   assign rsp_rel_r22 = rsp_ff[10];
   assign rsp_rel_tz  = rsp_ff[11];

endmodule

[rtl/core/rpfc_port_chk.sv]
// ----------------------------------------------------------------------------
// rpfc_port_chk
// Port-level checks of the relative pose block, bound to the top level.
// ----------------------------------------------------------------------------
`include "relative_pose_from_consecutive_top_assert.svh"

module rpfc_port_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_rel_r00,
   input logic signed [31:0] rsp_rel_r01,
   input logic signed [31:0] rsp_rel_r02,
   input logic signed [31:0] rsp_rel_tx,
   input logic signed [31:0] rsp_rel_r10,
   input logic signed [31:0] rsp_rel_r11,
   input logic signed [31:0] rsp_rel_r12,
   input logic signed [31:0] rsp_rel_ty,
   input logic signed [31:0] rsp_rel_r20,
   input logic signed [31:0] rsp_rel_r21,
   input logic signed [31:0] rsp_rel_r22,
   input logic signed [31:0] rsp_rel_tz
);

   logic [383:0] rsp_bus;

   assign rsp_bus = {rsp_rel_r00, rsp_rel_r01, rsp_rel_r02, rsp_rel_tx,
                     rsp_rel_r10, rsp_rel_r11, rsp_rel_r12, rsp_rel_ty,
                     rsp_rel_r20, rsp_rel_r21, rsp_rel_r22, rsp_rel_tz};

   // held result keeps its payload
   `RPFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_bus), "rsp item changed while stalled")

   // reset leaves the block empty and ready
   `RPFC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall, "not idle after reset")

   // a result is issued only once the computation has ended
   `RPFC_ASSERT_SAME(a_rsp_after_work, clock, reset, $rose(rsp_valid), !req_stall, "result issued while busy")

endmodule

bind relative_pose_from_consecutive_top rpfc_port_chk u_rpfc_port_chk (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Relative pose block: stream of absolute poses in, relative poses out. An
// in-bench predictor works out inv(prev) * cur exactly in wide integers.
// Results are checked field by field, in order, under random idling on both
// channels.
// ----------------------------------------------------------------------------
module tb_top;

   // one pose, index row*4 + col; col 3 is the translation
   typedef logic [11:0][31:0] pose_type;
   typedef logic signed [191:0] wide_type;

   localparam int  N_RANDOM   = 400;
   localparam int  LIMIT      = 4000000;   // cycle limit, many times the expected run time with stalls
   localparam int  CALM_FIRST = 60000;     // window with no idling on either side
   localparam int  CALM_LAST  = 120000;
   localparam int  IDLE_PCT   = 18;
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   pose_type req_pose = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   wire pose_type rsp_pose;

   // pending poses, and a flag that makes the sender wait for the output to drain
   pose_type pending_poses[$];
   bit       drain_first[$];
   pose_type expected_rel[$];

   // predictor state
   pose_type last_pose;
   bit       have_last;

   int  cycle_count = 0;
   int  mismatches  = 0;
   int  results_seen = 0;
   int  items_sent  = 0;
   int  sat_seen    = 0;
   bit  accepted    = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   relative_pose_from_consecutive_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cur_r00 (req_pose[0]),
      .req_cur_r01 (req_pose[1]),
      .req_cur_r02 (req_pose[2]),
      .req_cur_tx  (req_pose[3]),
      .req_cur_r10 (req_pose[4]),
      .req_cur_r11 (req_pose[5]),
      .req_cur_r12 (req_pose[6]),
      .req_cur_ty  (req_pose[7]),
      .req_cur_r20 (req_pose[8]),
      .req_cur_r21 (req_pose[9]),
      .req_cur_r22 (req_pose[10]),
      .req_cur_tz  (req_pose[11]),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_rel_r00 (rsp_pose[0]),
      .rsp_rel_r01 (rsp_pose[1]),
      .rsp_rel_r02 (rsp_pose[2]),
      .rsp_rel_tx  (rsp_pose[3]),
      .rsp_rel_r10 (rsp_pose[4]),
      .rsp_rel_r11 (rsp_pose[5]),
      .rsp_rel_r12 (rsp_pose[6]),
      .rsp_rel_ty  (rsp_pose[7]),
      .rsp_rel_r20 (rsp_pose[8]),
      .rsp_rel_r21 (rsp_pose[9]),
      .rsp_rel_r22 (rsp_pose[10]),
      .rsp_rel_tz  (rsp_pose[11])
   );

   // round(num * 2^30 / den), ties away from zero, saturated to 32 bits.
   // A zero determinant saturates on the sign of the numerator alone.
   function automatic logic [31:0] scaled_quotient(input wide_type num, input wide_type den);
      wide_type mag_n, mag_d, q;
      logic  neg;
      if (den == 0) begin
         if (num == 0) return 32'h0;
         return (num < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      neg   = (num < 0) != (den < 0);
      mag_n = (num < 0) ? -num : num;
      mag_d = (den < 0) ? -den : den;
      q     = ((mag_n <<< 30) + (mag_d >>> 1)) / mag_d;
      if (neg) begin
         if (q > 192'h8000_0000) q = 192'h8000_0000;
         return 32'(-q);
      end
      if (q > 192'h7FFF_FFFF) q = 192'h7FFF_FFFF;
      return q[31:0];
   endfunction

   // Applies one pose to the predictor; has_rel says whether a result follows.
   task automatic predict_relative(input pose_type cur, output bit has_rel,
                                   output pose_type rel);
      wide_type prev[12];
      wide_type now[12];
      wide_type adj[3][3];   // adj[k] = row(k+1) x row(k+2), column k of adj(A)
      wide_type det, num;
      int    ra, rb;
      for (int i = 0; i < 12; i++) begin
         prev[i] = $signed(last_pose[i]);
         now[i]  = $signed(cur[i]);
      end
      has_rel = have_last;
      rel     = '0;
      if (have_last) begin
         for (int k = 0; k < 3; k++) begin
            ra = ((k + 1) % 3) * 4;
            rb = ((k + 2) % 3) * 4;
            adj[k][0] = prev[ra+1] * prev[rb+2] - prev[ra+2] * prev[rb+1];
            adj[k][1] = prev[ra+2] * prev[rb+0] - prev[ra+0] * prev[rb+2];
            adj[k][2] = prev[ra+0] * prev[rb+1] - prev[ra+1] * prev[rb+0];
         end
         det = 0;
         for (int k = 0; k < 3; k++) det += prev[k] * adj[0][k];
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               num = 0;
               for (int k = 0; k < 3; k++) num += adj[k][i] * now[k*4+j];
               rel[i*4+j] = scaled_quotient(num, det);
            end
            num = 0;
            for (int k = 0; k < 3; k++) num += adj[k][i] * (now[k*4+3] - prev[k*4+3]);
            rel[i*4+3] = scaled_quotient(num, det);
         end
      end
      last_pose = cur;
      have_last = 1'b1;
   endtask

   function automatic bit idle_now();
      if (cycle_count >= CALM_FIRST && cycle_count < CALM_LAST) return 1'b0;
      return $urandom_range(99) < IDLE_PCT;
   endfunction

   // ---------------------------------------------------------------- driver
   // Changes inputs at the falling edge. A new item is offered once the
   // previous one was taken at the last rising edge.
   always @(negedge clock) begin
      if (!reset) begin
         rsp_stall <= idle_now();
         if (!req_valid || accepted) begin
            if (pending_poses.size() > 0 && !(drain_first[0] && expected_rel.size() > 0)
                && !idle_now()) begin
               req_pose  <= pending_poses.pop_front();
               void'(drain_first.pop_front());
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------- monitor
   always @(posedge clock) begin
      bit       has_rel;
      pose_type rel;
      pose_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_rel.size());
         $display("TEST FAILED");
         $finish;
      end
      accepted <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         items_sent++;
         predict_relative(req_pose, has_rel, rel);
         if (has_rel) expected_rel.insert(expected_rel.size(), rel);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_rel.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item at cycle %0d", cycle_count);
         end else begin
            want = expected_rel.pop_front();
            for (int i = 0; i < 12; i++) begin
               if (want[i] == 32'h7FFF_FFFF || want[i] == 32'h8000_0000) sat_seen++;
               if (rsp_pose[i] !== want[i]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d field %0d: expected %h, got %h",
                              results_seen, i, want[i], rsp_pose[i]);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------- stimulus
   function automatic pose_type near_identity();
      pose_type p;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++)
            p[i*4+j] = (i == j) ? ONE_Q30 + 32'($signed($urandom_range(8388608)) - 4194304)
                                : 32'($signed($urandom_range(134217728)) - 67108864);
         p[i*4+3] = $urandom;
      end
      return p;
   endfunction

   function automatic pose_type any_pose();
      pose_type p;
      for (int i = 0; i < 12; i++) p[i] = $urandom;
      return p;
   endfunction

   function automatic pose_type diag_pose(input logic [31:0] d, input logic [31:0] t);
      pose_type p;
      p = '0;
      for (int i = 0; i < 3; i++) begin
         p[i*5] = d;
         p[i*4+3] = t;
      end
      return p;
   endfunction

   task automatic queue_pose(input pose_type p, input bit drain);
      pending_poses.insert(pending_poses.size(), p);
      drain_first.insert(drain_first.size(), drain);
   endtask

   initial begin
      pose_type p;
      last_pose = '0;
      have_last = 1'b0;

      // directed: priming item, identity, translation extremes, singular
      // previous pose, all-max and all-min entries, overflowing quotients
      queue_pose(diag_pose(ONE_Q30, 32'h0), 1'b0);
      queue_pose(diag_pose(ONE_Q30, 32'h0001_0000), 1'b0);
      queue_pose(diag_pose(ONE_Q30, 32'h7FFF_FFFF), 1'b0);
      queue_pose(diag_pose(ONE_Q30, 32'h8000_0000), 1'b0);
      queue_pose('0, 1'b0);                                  // becomes singular previous
      queue_pose(diag_pose(ONE_Q30, 32'h1234_5678), 1'b0);   // result from zero det
      queue_pose(diag_pose(32'h0000_0001, 32'h0), 1'b0);     // tiny det next
      queue_pose(diag_pose(ONE_Q30, 32'hFFFF_0000), 1'b0);   // huge quotients saturate
      queue_pose({12{32'h7FFF_FFFF}}, 1'b0);                 // rank one
      queue_pose({12{32'h8000_0000}}, 1'b0);
      queue_pose(diag_pose(32'h8000_0000, 32'h8000_0000), 1'b0);
      queue_pose(diag_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0);
      p = diag_pose(ONE_Q30, 32'h0);
      p[1] = 32'h8000_0000; p[4] = 32'h7FFF_FFFF;            // cofactor terms at full swing
      queue_pose(p, 1'b0);
      queue_pose(diag_pose(32'hC000_0000, 32'h0), 1'b1);     // negative det, after a drain
      queue_pose(any_pose(), 1'b0);
      queue_pose(any_pose(), 1'b0);

      // random: mostly well-conditioned motion, some arbitrary and all-zero poses
      for (int n = 0; n < N_RANDOM; n++) begin
         p = ($urandom_range(99) < 75) ? near_identity() : any_pose();
         if ($urandom_range(99) < 3) p = '0;
         queue_pose(p, n == N_RANDOM / 2);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (pending_poses.size() == 0 && !req_valid);
      wait (expected_rel.size() == 0);
      repeat (2000) @(posedge clock);

      $display("%0d poses sent, %0d relative poses checked, %0d saturated fields",
               items_sent, results_seen, sat_seen);
      if (mismatches == 0 && expected_rel.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/rpfc_pkg.sv
rtl/core/rpfc_div.sv
rtl/core/relative_pose_from_consecutive_top.sv
rtl/core/rpfc_port_chk.sv
test/tb_top.sv
